// File: hdl/fcc_pkg.sv
// Package with the shared types, constants and bit-order helpers of the CRC-32 frame checker.
package fcc_pkg;

    localparam int          FRAME_WORDS_DEF = 11;
    localparam int          PADDR_W         = 3;
    localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [31:0] POLY_RESET      = 32'hEDB8_8320;
    localparam logic        REG_POLY        = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] computed_crc;
        logic        crc_match;
    } t_out_item;

    typedef struct packed {
        logic      produce;
        t_out_item item;
    } t_core_res;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = b[7 - k];
        end
        return r;
    endfunction

    function automatic logic [31:0] bytewise_rev(input logic [31:0] v);
        return {rev8(v[31:24]), rev8(v[23:16]), rev8(v[15:8]), rev8(v[7:0])};
    endfunction

endpackage

// File: hdl/fcc_byte_step.sv
// One reflected CRC-32 byte step with the table entry derived from the polynomial register.
module fcc_byte_step (
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_poly,
    output logic [31:0] o_crc
);

    logic [31:0] c;

    always_comb begin
        c = {24'd0, i_crc[7:0] ^ i_byte};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ i_poly) : (c >> 1);
        end
        o_crc = (i_crc >> 8) ^ c;
    end

endmodule

// File: hdl/fcc_frame_core.sv
// Frame position tracking, word buffering, CRC feed sequencing and check comparison.
module fcc_frame_core #(
    parameter int FRAME_WORDS = fcc_pkg::FRAME_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic               i_item_valid,
    input  fcc_pkg::t_in_item  i_item,
    input  logic [31:0]        i_poly,
    output fcc_pkg::t_core_res o_res
);
    import fcc_pkg::*;

    localparam int DATA_BYTES = 4 * FRAME_WORDS;
    localparam int POS_W      = $clog2(DATA_BYTES + 4);
    localparam logic [POS_W-1:0] DATA_POS = POS_W'(DATA_BYTES);

    logic [POS_W-1:0] r_pos, n_pos, pos_e;
    logic [31:0]      r_crc, n_crc, crc_e;
    logic [23:0]      r_word, n_word, word_e;
    logic [23:0]      r_check, n_check, check_e;
    logic [23:0]      r_pend, n_pend;
    logic [1:0]       r_feed_cnt, n_feed_cnt;

    logic        in_data;
    logic        complete;
    logic        engine_on;
    logic [31:0] step_in;
    logic [7:0]  step_byte;
    logic [31:0] step_out;
    logic [31:0] computed;

    fcc_byte_step u_step (
        .i_crc  (step_in),
        .i_byte (step_byte),
        .i_poly (i_poly),
        .o_crc  (step_out)
    );

    always_comb begin
        if (i_item.first_byte) begin
            pos_e   = '0;
            crc_e   = CRC_INIT;
            word_e  = '0;
            check_e = '0;
        end else begin
            pos_e   = r_pos;
            crc_e   = r_crc;
            word_e  = r_word;
            check_e = r_check;
        end
        in_data   = (pos_e < DATA_POS);
        complete  = i_go && in_data && (pos_e[1:0] == 2'd3);
        engine_on = (r_feed_cnt != 2'd0) && !(i_go && i_item.first_byte);
        step_in   = complete ? crc_e : r_crc;
        step_byte = complete ? rev8(i_item.data_byte) : rev8(r_pend[23:16]);
        computed  = bytewise_rev(r_crc);

        o_res.produce                = i_item_valid && !in_data && (pos_e[1:0] == 2'd3);
        o_res.item.computed_crc      = computed;
        o_res.item.crc_match         = ({check_e, i_item.data_byte} == computed);
    end

    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_word     = r_word;
        n_check    = r_check;
        n_pend     = r_pend;
        n_feed_cnt = r_feed_cnt;
        if (engine_on) begin
            n_crc      = step_out;
            n_pend     = {r_pend[15:0], 8'd0};
            n_feed_cnt = r_feed_cnt - 2'd1;
        end
        if (i_go) begin
            n_crc   = engine_on ? step_out : crc_e;
            n_word  = word_e;
            n_check = check_e;
            n_pos   = pos_e + POS_W'(1);
            if (i_item.first_byte) begin
                n_feed_cnt = 2'd0;
            end
            if (in_data) begin
                case (pos_e[1:0])
                    2'd0: n_word[7:0]   = i_item.data_byte;
                    2'd1: n_word[15:8]  = i_item.data_byte;
                    2'd2: n_word[23:16] = i_item.data_byte;
                    default: begin
                        n_crc      = step_out;
                        n_pend     = word_e;
                        n_feed_cnt = 2'd3;
                        n_word     = '0;
                    end
                endcase
            end else if (pos_e[1:0] != 2'd3) begin
                n_check = {check_e[15:0], i_item.data_byte};
            end else begin
                n_pos      = '0;
                n_crc      = CRC_INIT;
                n_word     = '0;
                n_check    = '0;
                n_feed_cnt = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_crc      <= CRC_INIT;
            r_word     <= '0;
            r_check    <= '0;
            r_feed_cnt <= 2'd0;
        end else begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_word     <= n_word;
            r_check    <= n_check;
            r_feed_cnt <= n_feed_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

// File: hdl/frame_crc32_checker_unit.sv
// Top level of the CRC-32 frame checker: input register, register port, core and result register.
// A byte accepted at a clock edge is held in the input register while the core processes it, and
// the result of the last check byte is then loaded into the output register.
// Throughput: one byte per cycle unless a finished result waits on a stalled output; the four CRC
// feeds of a word run one per cycle through a single byte step unit as the next bytes arrive.
// Reset: synchronous and active low; the CRC returns to all ones, the position to zero and the
// polynomial register to 0xEDB88320.
module frame_crc32_checker_unit #(
    parameter int FRAME_WORDS = fcc_pkg::FRAME_WORDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  fcc_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output fcc_pkg::t_out_item           o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fcc_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [31:0] r_poly;
    logic        go;
    t_core_res   res;

    fcc_frame_core #(
        .FRAME_WORDS (FRAME_WORDS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .i_poly       (r_poly),
        .o_res        (res)
    );

    assign go          = r_in_valid && !(res.produce && r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && !go;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[PADDR_W-1] == REG_POLY) ? r_poly : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RESET;
        end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_POLY)) begin
            r_poly <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && res.produce) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && res.produce) begin
            r_out <= res.item;
        end
    end

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && res.produce |=> r_out_valid)
        else $error("result was not captured in the output register");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !go |=> r_in_valid && $stable(r_in))
        else $error("input register changed while its byte was blocked");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("reset did not clear the valid flags");

endmodule
